// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the wall clock block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SHWC_ASSERT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);
`define SHWC_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);
`else
`define SHWC_ASSERT(label, clk, rst, cond, conseq, msg)
`define SHWC_ASSERT_NEXT(label, clk, rst, cond, conseq, msg)
`endif

`endif

// ===== hw/rtl/shwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall clock package
// Command codes, character constants, queue word type and digit helpers.
// ----------------------------------------------------------------------------
package shwc_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic KIND_TIME  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [28:0] RECIP_1000 = 29'd274877907;
  localparam logic [22:0] RECIP_60   = 23'd4473925;
  localparam logic [11:0] RECIP_24   = 12'd2731;

  typedef struct packed {
    logic        kind;
    logic [30:0] now_ms;
    logic [30:0] base_ms;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } q_word_t;

  function automatic logic digit_ok(input logic [7:0] c, input logic [3:0] maxv);
    logic [7:0] d;
    d = c - CHAR_ZERO;
    return (c >= CHAR_ZERO) && (d <= {4'd0, maxv});
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_ZERO;
    return d[3:0];
  endfunction

  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] r;
    r = v - 6'(tens_of(v)) * 6'd10;
    return r[3:0];
  endfunction

endpackage

// ===== hw/rtl/shwc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall clock channel interfaces
// Command channel and display channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface shwc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [30:0] now_ms;
  logic [7:0] hour_tens_char;
  logic [7:0] hour_ones_char;
  logic [7:0] first_sep_char;
  logic [7:0] min_tens_char;
  logic [7:0] min_ones_char;
  logic [7:0] second_sep_char;
  logic [7:0] sec_tens_char;
  logic [7:0] sec_ones_char;
  logic [7:0] end_char;

  modport source (output valid, mode, now_ms, hour_tens_char, hour_ones_char,
                  first_sep_char, min_tens_char, min_ones_char, second_sep_char,
                  sec_tens_char, sec_ones_char, end_char, input ready);
  modport sink (input valid, mode, now_ms, hour_tens_char, hour_ones_char,
                first_sep_char, min_tens_char, min_ones_char, second_sep_char,
                sec_tens_char, sec_ones_char, end_char, output ready);
endinterface

interface shwc_disp_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] hours_tens;
  logic [3:0] hours_ones;
  logic [2:0] minutes_tens;
  logic [3:0] minutes_ones;
  logic [2:0] seconds_tens;
  logic [3:0] seconds_ones;

  modport source (output valid, kind, hours_tens, hours_ones, minutes_tens,
                  minutes_ones, seconds_tens, seconds_ones, input ready);
  modport sink (input valid, kind, hours_tens, hours_ones, minutes_tens,
                minutes_ones, seconds_tens, seconds_ones, output ready);
endinterface

// ===== hw/rtl/settable_hms_wall_clock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Settable hh:mm:ss wall clock
// Top level: front end, job queue and display back end.
// ----------------------------------------------------------------------------
// The clock accepts one command word per cycle while its job queue has room.
// Start, stop and valid set commands only update the running flag, base time
// and time offset in the front end. A tick while running and a malformed set
// command queue a job; the back end is a nine-stage pipeline that takes one job
// per cycle while the display channel does not hold it off, and presents a
// display or error word. Ticks with less than one second elapsed, or a negative
// elapsed count, produce no word. The command channel stalls only in reset or
// when the QUEUE_DEPTH-entry queue fills while the display channel is held off.
module settable_hms_wall_clock
  import shwc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  shwc_cmd_if.sink    cmd,
  shwc_disp_if.source disp
);

  logic    q_full;
  logic    push;
  q_word_t push_data;
  logic    pop;
  logic    q_valid;
  q_word_t q_data;

  shwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  shwc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  shwc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .disp    (disp)
  );

endmodule

// ===== hw/rtl/shwc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall clock front end
// Accepts command words, validates set commands, keeps the clock state and
// queues display and error jobs for the back end.
// ----------------------------------------------------------------------------
module shwc_front
  import shwc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  shwc_cmd_if.sink cmd,
  input  logic    q_full,
  output logic    push,
  output q_word_t push_data
);

  logic        running;
  logic [30:0] base_ms;
  logic [4:0]  off_hour;
  logic [5:0]  off_minute;
  logic [5:0]  off_second;

  logic       accept;
  logic       set_ok;
  logic [4:0] set_hour;
  logic [5:0] set_minute;
  logic [5:0] set_second;
  logic [3:0] h1, h0;

  assign cmd.ready = !q_full && !rst;
  assign accept = cmd.valid && cmd.ready;

  always_comb begin
    h1 = digit_val(cmd.hour_tens_char);
    h0 = digit_val(cmd.hour_ones_char);
    set_ok = digit_ok(cmd.hour_tens_char, 4'd2) && digit_ok(cmd.hour_ones_char, 4'd9) &&
             !((h1 == 4'd2) && (h0 > 4'd3)) &&
             (cmd.first_sep_char == CHAR_COLON) &&
             digit_ok(cmd.min_tens_char, 4'd5) && digit_ok(cmd.min_ones_char, 4'd9) &&
             (cmd.second_sep_char == CHAR_COLON) &&
             digit_ok(cmd.sec_tens_char, 4'd5) && digit_ok(cmd.sec_ones_char, 4'd9) &&
             (cmd.end_char == CHAR_CR);
    set_hour   = 5'(h1) * 5'd10 + 5'(h0);
    set_minute = 6'(digit_val(cmd.min_tens_char)) * 6'd10 + 6'(digit_val(cmd.min_ones_char));
    set_second = 6'(digit_val(cmd.sec_tens_char)) * 6'd10 + 6'(digit_val(cmd.sec_ones_char));
  end

  always_comb begin
    push_data.kind    = (cmd.mode == MODE_SET) ? KIND_ERROR : KIND_TIME;
    push_data.now_ms  = cmd.now_ms;
    push_data.base_ms = base_ms;
    push_data.hour    = off_hour;
    push_data.minute  = off_minute;
    push_data.second  = off_second;
    case (cmd.mode)
      MODE_TICK: push = accept && running;
      MODE_SET:  push = accept && !set_ok;
      default:   push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      base_ms    <= '0;
      off_hour   <= '0;
      off_minute <= '0;
      off_second <= '0;
    end else if (accept) begin
      case (cmd.mode)
        MODE_START: begin
          running    <= 1'b1;
          base_ms    <= cmd.now_ms;
          off_hour   <= '0;
          off_minute <= '0;
          off_second <= '0;
        end
        MODE_SET: begin
          if (set_ok) begin
            running    <= 1'b1;
            base_ms    <= cmd.now_ms;
            off_hour   <= set_hour;
            off_minute <= set_minute;
            off_second <= set_second;
          end
        end
        MODE_STOP: begin
          running <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/shwc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall clock job queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module shwc_queue
  import shwc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_word_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output q_word_t q_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_word_t        mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SHWC_ASSERT(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "queue count overflow")
  `SHWC_ASSERT(a_no_push_full, clk, rst, push, !full || pop, "push into full queue")
  `SHWC_ASSERT(a_no_pop_empty, clk, rst, pop, q_valid, "pop from empty queue")
  `SHWC_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1,
    "queue count did not follow a push")

endmodule

// ===== hw/rtl/shwc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall clock back end
// Pipeline that turns an elapsed count into hours, minutes and seconds digits,
// drops negative ticks and ticks under one second and formats error results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module shwc_back
  import shwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  q_word_t   q_data,
  output logic      pop,
  shwc_disp_if.source disp
);

  logic        en;
  logic        v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic        k1, k2, k3, k4, k5, k6, k7, k8, k9;
  logic [31:0] diff1, diff2;
  logic [16:0] hms1;
  logic [26:0] setms2;
  logic [31:0] el3;
  logic [21:0] secs4, secs5;
  logic [15:0] mins5, mins6;
  logic [5:0]  sec6, sec7, sec8;
  logic [9:0]  hrs6, hrs7;
  logic [5:0]  min7, min8;
  logic [4:0]  q7;
  logic [4:0]  hr8;
  logic [1:0]  o_ht;
  logic [3:0]  o_ho;
  logic [2:0]  o_mt;
  logic [3:0]  o_mo;
  logic [2:0]  o_st;
  logic [3:0]  o_so;

  logic        keep3;
  logic [59:0] p1000;
  logic [44:0] p60a;
  logic [38:0] p60b;
  logic [21:0] p24;

  assign en  = !v9 || disp.ready;
  assign pop = en && q_valid;

  always_comb begin
    keep3 = k3 || (!el3[31] && (el3 >= 32'd1000));
    p1000 = {29'd0, el3[30:0]} * {31'd0, RECIP_1000};
    p60a  = {23'd0, secs4} * {22'd0, RECIP_60};
    p60b  = {23'd0, mins5} * {16'd0, RECIP_60};
    p24   = {12'd0, hrs6} * {10'd0, RECIP_24};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && keep3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1    <= q_data.kind;
      diff1 <= {1'b0, q_data.now_ms} - {1'b0, q_data.base_ms};
      hms1  <= 17'(q_data.hour) * 17'd3600 + 17'(q_data.minute) * 17'd60 +
               17'(q_data.second);

      k2     <= k1;
      diff2  <= diff1;
      setms2 <= 27'(hms1) * 27'd1000;

      k3  <= k2;
      el3 <= diff2 + {5'd0, setms2};

      k4    <= k3;
      secs4 <= p1000[59:38];

      k5    <= k4;
      secs5 <= secs4;
      mins5 <= p60a[43:28];

      k6    <= k5;
      sec6  <= 6'(secs5 - 22'(mins5) * 22'd60);
      mins6 <= mins5;
      hrs6  <= p60b[37:28];

      k7   <= k6;
      sec7 <= sec6;
      min7 <= 6'(mins6 - 16'(hrs6) * 16'd60);
      hrs7 <= hrs6;
      q7   <= p24[20:16];

      k8   <= k7;
      sec8 <= sec7;
      min8 <= min7;
      hr8  <= 5'(hrs7 - 10'(q7) * 10'd24);

      k9 <= k8;
      if (k8 == KIND_ERROR) begin
        {o_ht, o_ho, o_mt, o_mo, o_st, o_so} <= '0;
      end else begin
        o_ht <= 2'(tens_of({1'b0, hr8}));
        o_ho <= ones_of({1'b0, hr8});
        o_mt <= tens_of(min8);
        o_mo <= ones_of(min8);
        o_st <= tens_of(sec8);
        o_so <= ones_of(sec8);
      end
    end
  end

  assign disp.valid        = v9;
  assign disp.kind         = k9;
  assign disp.hours_tens   = o_ht;
  assign disp.hours_ones   = o_ho;
  assign disp.minutes_tens = o_mt;
  assign disp.minutes_ones = o_mo;
  assign disp.seconds_tens = o_st;
  assign disp.seconds_ones = o_so;

  `SHWC_ASSERT(a_error_zero, clk, rst, v9 && (k9 == KIND_ERROR),
    (o_ht == 2'd0) && (o_ho == 4'd0) && (o_mt == 3'd0) && (o_mo == 4'd0) &&
    (o_st == 3'd0) && (o_so == 4'd0), "error result carries nonzero digits")
  `SHWC_ASSERT(a_digit_range, clk, rst, v9 && (k9 == KIND_TIME),
    (o_ht <= 2'd2) && (o_ho <= 4'd9) && (o_mt <= 3'd5) && (o_mo <= 4'd9) &&
    (o_st <= 3'd5) && (o_so <= 4'd9) && !((o_ht == 2'd2) && (o_ho > 4'd3)),
    "time digits out of range")
  `SHWC_ASSERT(a_secs_nonzero, clk, rst, v4 && (k4 == KIND_TIME), secs4 != '0,
    "kept tick has less than one second")
  `SHWC_ASSERT_NEXT(a_hold_stall, clk, rst, v9 && !disp.ready, v9,
    "result dropped while stalled")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall clock testbench
// Drives start, stop, set and tick words into the command channel, predicts
// each display or error word from a behavioral copy of the clock, and checks
// every display word field by field under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top
  import shwc_pkg::*;
();

  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_WORDS  = 650;
  localparam int HOLD_CYCLES   = 300;
  localparam int MS_PER_SEC    = 1000;

  typedef struct packed {
    logic [1:0]      mode;
    logic [30:0]     now_ms;
    logic [8:0][7:0] text;
  } clock_cmd_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] hours_tens;
    logic [3:0] hours_ones;
    logic [2:0] minutes_tens;
    logic [3:0] minutes_ones;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_ones;
  } display_word_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_HALF,
    RX_TWO_OF_THREE,
    RX_MOSTLY
  } rx_pattern_t;

  logic clk;
  logic rst;

  shwc_cmd_if  cmd_bus ();
  shwc_disp_if disp_bus ();

  settable_hms_wall_clock u_dut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_bus),
    .disp (disp_bus)
  );

  display_word_t pending_displays[$];
  int            error_count;
  bit            wall_running;
  logic [31:0]   wall_base_ms;
  logic [30:0]   wall_now_ms;
  bit            sender_gaps;
  int            burst_left;
  int            hold_left;
  rx_pattern_t   rx_pattern;
  int            rx_pattern_left;
  int            rx_cycle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [3:0] got,
                             input logic [3:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic bit char_digit(input logic [7:0] ch, input int unsigned maxv,
                                    output int unsigned val);
    val = ch - CHAR_ZERO;
    return (ch >= CHAR_ZERO) && (ch <= CHAR_ZERO + 8'd9) && (val <= maxv);
  endfunction

  // Updates the clock state for one accepted word and returns whether a
  // display word results from it.
  function automatic bit advance_wall_clock(input clock_cmd_t c,
                                            output display_word_t word);
    int unsigned h1, h0, m1, m0, s1, s0, secs, hr, mn, sc;
    bit          ok;
    logic [31:0] elapsed;
    word = '0;
    case (c.mode)
      MODE_START: begin
        wall_running = 1'b1;
        wall_base_ms = {1'b0, c.now_ms};
      end
      MODE_STOP: begin
        wall_running = 1'b0;
      end
      MODE_SET: begin
        ok = char_digit(c.text[8], 2, h1) & char_digit(c.text[7], 9, h0) &
             char_digit(c.text[5], 5, m1) & char_digit(c.text[4], 9, m0) &
             char_digit(c.text[2], 5, s1) & char_digit(c.text[1], 9, s0);
        ok = ok && !(h1 == 2 && h0 > 3) && (c.text[6] == CHAR_COLON) &&
             (c.text[3] == CHAR_COLON) && (c.text[0] == CHAR_CR);
        if (!ok) begin
          word.kind = KIND_ERROR;
          return 1'b1;
        end
        wall_running = 1'b1;
        wall_base_ms = {1'b0, c.now_ms} - 32'(MS_PER_SEC *
                       ((h1 * 10 + h0) * 3600 + (m1 * 10 + m0) * 60 + s1 * 10 + s0));
      end
      MODE_TICK: begin
        if (!wall_running) return 1'b0;
        elapsed = {1'b0, c.now_ms} - wall_base_ms;
        if (elapsed[31] || elapsed < MS_PER_SEC) return 1'b0;
        secs = elapsed / MS_PER_SEC;
        sc = secs % 60;
        mn = (secs / 60) % 60;
        hr = (secs / 3600) % 24;
        word.kind         = KIND_TIME;
        word.hours_tens   = 2'(hr / 10);
        word.hours_ones   = 4'(hr % 10);
        word.minutes_tens = 3'(mn / 10);
        word.minutes_ones = 4'(mn % 10);
        word.seconds_tens = 3'(sc / 10);
        word.seconds_ones = 4'(sc % 10);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic clock_cmd_t set_cmd(input logic [30:0] now, input string hms);
    clock_cmd_t c;
    c.mode   = MODE_SET;
    c.now_ms = now;
    for (int i = 0; i < 8; i++) begin
      c.text[8 - i] = hms[i];
    end
    c.text[0] = CHAR_CR;
    return c;
  endfunction

  function automatic clock_cmd_t plain_cmd(input logic [1:0] mode, input logic [30:0] now);
    clock_cmd_t c;
    c.mode   = mode;
    c.now_ms = now;
    c.text   = '0;
    return c;
  endfunction

  task automatic send_cmd(input clock_cmd_t c);
    int            gap;
    display_word_t word;
    if (sender_gaps && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    cmd_bus.valid           <= 1'b1;
    cmd_bus.mode            <= c.mode;
    cmd_bus.now_ms          <= c.now_ms;
    cmd_bus.hour_tens_char  <= c.text[8];
    cmd_bus.hour_ones_char  <= c.text[7];
    cmd_bus.first_sep_char  <= c.text[6];
    cmd_bus.min_tens_char   <= c.text[5];
    cmd_bus.min_ones_char   <= c.text[4];
    cmd_bus.second_sep_char <= c.text[3];
    cmd_bus.sec_tens_char   <= c.text[2];
    cmd_bus.sec_ones_char   <= c.text[1];
    cmd_bus.end_char        <= c.text[0];
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    burst_left--;
    if (advance_wall_clock(c, word)) pending_displays.push_back(word);
  endtask

  task automatic wait_all_displayed();
    cmd_bus.valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    clock_cmd_t c;
    send_cmd(plain_cmd(MODE_TICK, 31'd5000));
    send_cmd(plain_cmd(MODE_START, 31'd0));
    send_cmd(plain_cmd(MODE_TICK, 31'd999));
    send_cmd(plain_cmd(MODE_TICK, 31'd1000));
    send_cmd(plain_cmd(MODE_TICK, 31'h7FFF_FFFF));
    send_cmd(set_cmd(31'd100, "23:59:59"));
    send_cmd(plain_cmd(MODE_TICK, 31'd1100));
    send_cmd(set_cmd(31'd200, "24:00:00"));
    send_cmd(set_cmd(31'd200, "30:00:00"));
    send_cmd(set_cmd(31'd200, "12;00:00"));
    send_cmd(set_cmd(31'd200, "12:60:00"));
    send_cmd(set_cmd(31'd200, "12:00:60"));
    send_cmd(set_cmd(31'd200, "1/:00:00"));
    send_cmd(set_cmd(31'd200, "12:0::00"));
    c = set_cmd(31'd200, "12:00:00");
    c.text[0] = 8'h0A;
    send_cmd(c);
    c.text = '1;
    send_cmd(c);
    c.text = '0;
    send_cmd(c);
    send_cmd(set_cmd(31'h7FFF_FFFF, "00:00:00"));
    send_cmd(plain_cmd(MODE_TICK, 31'd0));
    send_cmd(plain_cmd(MODE_STOP, 31'd0));
    send_cmd(plain_cmd(MODE_TICK, 31'd90000));
    send_cmd(set_cmd(31'd300, "2a:00:00"));
    send_cmd(plain_cmd(MODE_TICK, 31'd90000));
    send_cmd(set_cmd(31'd500, "09:45:30"));
    send_cmd(plain_cmd(MODE_TICK, 31'd1500));
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    send_cmd(set_cmd(31'd1000, "20:00:00"));
    hold_left = HOLD_CYCLES;
    for (int i = 1; i <= 40; i++) begin
      send_cmd(plain_cmd(MODE_TICK, 31'(1000 + i * 1777)));
    end
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    clock_cmd_t c;
    int         pick;
    int         jump;
    wall_now_ms = 31'd0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      jump = $urandom_range(0, 99);
      if (jump < 70) wall_now_ms = wall_now_ms + 31'($urandom_range(0, 5000));
      else if (jump < 90) wall_now_ms = wall_now_ms + 31'($urandom_range(0, 10_000_000));
      else if (jump < 97) wall_now_ms = wall_now_ms + 31'($urandom_range(0, 200_000_000));
      else wall_now_ms = 31'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        c = set_cmd(wall_now_ms, $sformatf("%02d:%02d:%02d", $urandom_range(0, 23),
                                           $urandom_range(0, 59), $urandom_range(0, 59)));
        if (pick < 55) begin
          c.mode = MODE_TICK;
          c.text = 72'({$urandom(), $urandom(), $urandom()});
        end else if (pick < 57) begin
          c.text = 72'({$urandom(), $urandom(), $urandom()});
        end else if (pick < 59) begin
          c.text[$urandom_range(0, 8)] = 8'($urandom());
        end
      end else begin
        c.now_ms = wall_now_ms;
        c.text   = 72'({$urandom(), $urandom(), $urandom()});
        if (pick < 72) c.mode = MODE_START;
        else if (pick < 92) c = set_cmd(wall_now_ms,
                                        $sformatf("%02d:%02d:%02d", $urandom_range(0, 23),
                                                  $urandom_range(0, 59),
                                                  $urandom_range(0, 59)));
        else c.mode = MODE_STOP;
      end
      send_cmd(c);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      disp_bus.ready <= 1'b0;
      rx_pattern_left = 0;
    end else if (hold_left > 0) begin
      disp_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      if (rx_pattern_left <= 0) begin
        rx_pattern      = rx_pattern_t'($urandom_range(0, 3));
        rx_pattern_left = $urandom_range(20, 80);
      end
      rx_pattern_left--;
      rx_cycle++;
      case (rx_pattern)
        RX_ALWAYS:       disp_bus.ready <= 1'b1;
        RX_HALF:         disp_bus.ready <= 1'($urandom_range(0, 1));
        RX_TWO_OF_THREE: disp_bus.ready <= (rx_cycle % 3) != 0;
        RX_MOSTLY:       disp_bus.ready <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    display_word_t want;
    if (!rst && disp_bus.valid && disp_bus.ready) begin
      if (pending_displays.size() == 0) begin
        report_mismatch("display word arrived with none expected");
      end else begin
        want = pending_displays.pop_front();
        check_field("kind", 4'(disp_bus.kind), 4'(want.kind));
        check_field("hours_tens", 4'(disp_bus.hours_tens), 4'(want.hours_tens));
        check_field("hours_ones", disp_bus.hours_ones, want.hours_ones);
        check_field("minutes_tens", 4'(disp_bus.minutes_tens), 4'(want.minutes_tens));
        check_field("minutes_ones", disp_bus.minutes_ones, want.minutes_ones);
        check_field("seconds_tens", 4'(disp_bus.seconds_tens), 4'(want.seconds_tens));
        check_field("seconds_ones", disp_bus.seconds_ones, want.seconds_ones);
      end
    end
  end

  initial begin
    error_count  = 0;
    wall_running = 1'b0;
    wall_base_ms = '0;
    sender_gaps  = 1'b1;
    burst_left   = 0;
    hold_left    = 0;
    rx_cycle     = 0;
    rst                     <= 1'b1;
    cmd_bus.valid           <= 1'b0;
    cmd_bus.mode            <= MODE_TICK;
    cmd_bus.now_ms          <= '0;
    cmd_bus.hour_tens_char  <= '0;
    cmd_bus.hour_ones_char  <= '0;
    cmd_bus.first_sep_char  <= '0;
    cmd_bus.min_tens_char   <= '0;
    cmd_bus.min_ones_char   <= '0;
    cmd_bus.second_sep_char <= '0;
    cmd_bus.sec_tens_char   <= '0;
    cmd_bus.sec_ones_char   <= '0;
    cmd_bus.end_char        <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    wait_all_displayed();
    test_backpressure();
    wait_all_displayed();
    test_random_traffic();
    wait_all_displayed();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/shwc_pkg.sv
hw/rtl/shwc_if.sv
hw/rtl/shwc_front.sv
hw/rtl/shwc_queue.sv
hw/rtl/shwc_back.sv
hw/rtl/settable_hms_wall_clock.sv
tb/tb_top.sv
